/* hdl/tmt_pkg.sv */
// Shared types, constants and opcodes for the text mode terminal engine.
`default_nettype none
package tmt_pkg;
    localparam int MAX_COLS   = 80;
    localparam int MAX_ROWS   = 60;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int IDX_W  = 13;
    localparam int CELL_W = 16;
    localparam int CFG_W  = 7;

    localparam logic [7:0] ATTR_DEFAULT = 8'h07;

    localparam logic [0:0] CFG_COLS = 1'b0;
    localparam logic [0:0] CFG_ROWS = 1'b1;

    localparam logic [7:0] CC_NUL      = 8'h00;
    localparam logic [7:0] CC_SAVE_BG  = 8'h01;
    localparam logic [7:0] CC_REST_BG  = 8'h02;
    localparam logic [7:0] CC_CLEAR    = 8'h03;
    localparam logic [7:0] CC_SET_CUR  = 8'h04;
    localparam logic [7:0] CC_SAVE_CUR = 8'h05;
    localparam logic [7:0] CC_REST_CUR = 8'h06;
    localparam logic [7:0] CC_SET_REG  = 8'h07;
    localparam logic [7:0] CC_SCR_UP   = 8'h08;
    localparam logic [7:0] CC_SCR_DN   = 8'h09;
    localparam logic [7:0] CC_NEWLINE  = 8'h0A;
    localparam logic [7:0] CC_SET_ATTR = 8'h0B;

    // operations handed from the front to the back
    typedef enum logic [3:0] {
        OP_NOP, OP_READ, OP_PUT, OP_CLEAR, OP_SET_CUR, OP_SAVE_CUR, OP_REST_CUR,
        OP_SET_REG, OP_SCR_UP, OP_SCR_DN, OP_NEWLINE
    } op_t;

    typedef enum logic [1:0] {K_NONE, K_CURSOR, K_REGION, K_ATTR} kind_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       arg_a;
        logic [7:0]       arg_b;
        logic [IDX_W-1:0] idx;
    } fe_word_t;

    typedef enum logic [2:0] {
        BS_IDLE, BS_READ, BS_CLEAR, BS_MOVE_RD, BS_MOVE_WR, BS_FILL, BS_OUT
    } bstate_t;
endpackage
`default_nettype wire

/* hdl/text_mode_terminal_engine_top.sv */
// Top level of the text mode terminal engine.
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_tvalid/s_tready      | s_tdata, s_tuser = cmd
//  m_axis  | out | m_tvalid/m_tready      | m_tdata
//  cfg     | in  | cfg_we                 | cfg_index, cfg_data
// A byte passes the queue register and the back end idle and output states; a read
// also passes the read state. Clear writes every cell of rows*cols; a scroll moves
// each cell of the region with a read state and a write state, then blanks one row.
// After reset a clearing pass writes all 4800 cells before the first word is taken.
// While a result waits, the back end takes no word, but the front end can hold one more.
`default_nettype none
module text_mode_terminal_engine_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] stream_byte, [20:8] read_index
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // col[6:0] row[12:7] offset[25:13] cell[41:26]
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);
    import tmt_pkg::*;

    logic              q_valid, q_ready;
    fe_word_t          q_word;
    logic [COL_W-1:0]  o_col;
    logic [ROW_W-1:0]  o_row;
    logic [IDX_W-1:0]  o_off;
    logic [CELL_W-1:0] o_cell;

    tmt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .in_byte(s_tdata[7:0]), .in_idx(s_tdata[20:8]),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    tmt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_col(o_col), .out_row(o_row), .out_offset(o_off), .out_cell(o_cell)
    );

    assign m_tdata = {6'd0, o_cell, o_off, o_row, o_col};

    logic unused_hi;
    assign unused_hi = ^s_tdata[23:21];
endmodule
`default_nettype wire

/* hdl/tmt_front.sv */
// Front end: decodes stream bytes and argument sequences into operations.
`default_nettype none
module tmt_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_cmd,
    input  wire logic [7:0]        in_byte,
    input  wire logic [tmt_pkg::IDX_W-1:0] in_idx,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output tmt_pkg::fe_word_t      q_word
);
    import tmt_pkg::*;

    logic       phase_reg, phase_next;   // 1: waiting for second argument
    logic       pend_reg, pend_next;     // an argument is pending
    kind_t      kind_reg, kind_next;
    logic [7:0] first_reg, first_next;
    fe_word_t   qw_reg, qw_next;
    logic       qv_reg, qv_next;
    logic       take;

    assign in_ready = !qv_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign q_valid  = qv_reg;
    assign q_word   = qw_reg;

    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        kind_next  = kind_reg;
        first_next = first_reg;
        qw_next    = qw_reg;
        qv_next    = qv_reg && !q_ready;
        if (take) begin
            qv_next       = 1'b1;
            qw_next.op    = OP_NOP;
            qw_next.arg_a = first_reg;
            qw_next.arg_b = in_byte;
            qw_next.idx   = in_idx;
            if (in_cmd) begin
                qw_next.op = OP_READ;
            end else if (pend_reg) begin
                if (!phase_reg && kind_reg != K_ATTR) begin
                    first_next = in_byte;
                    phase_next = 1'b1;
                end else begin
                    if (kind_reg == K_CURSOR) qw_next.op = OP_SET_CUR;
                    else if (kind_reg == K_REGION) qw_next.op = OP_SET_REG;
                    pend_next  = 1'b0;
                    phase_next = 1'b0;
                    kind_next  = K_NONE;
                end
            end else begin
                case (in_byte)
                    CC_NUL, CC_SAVE_BG, CC_REST_BG: qw_next.op = OP_NOP;
                    CC_CLEAR:    qw_next.op = OP_CLEAR;
                    CC_SET_CUR:  begin kind_next = K_CURSOR; pend_next = 1'b1; end
                    CC_SAVE_CUR: qw_next.op = OP_SAVE_CUR;
                    CC_REST_CUR: qw_next.op = OP_REST_CUR;
                    CC_SET_REG:  begin kind_next = K_REGION; pend_next = 1'b1; end
                    CC_SCR_UP:   qw_next.op = OP_SCR_UP;
                    CC_SCR_DN:   qw_next.op = OP_SCR_DN;
                    CC_NEWLINE:  qw_next.op = OP_NEWLINE;
                    CC_SET_ATTR: begin kind_next = K_ATTR; pend_next = 1'b1; end
                    default:     qw_next.op = OP_PUT;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            pend_reg  <= 1'b0;
            kind_reg  <= K_NONE;
            first_reg <= 8'd0;
            qv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            kind_reg  <= kind_next;
            first_reg <= first_next;
            qv_reg    <= qv_next;
        end
        qw_reg <= qw_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> pend_reg && kind_reg != K_ATTR)
        else $error("second argument phase without a pending two-byte code");
    assert property (@(posedge aclk) disable iff (!aresetn)
        qv_reg && !q_ready |=> qv_reg && $stable(qw_reg))
        else $error("queued word changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_cmd |=> pend_reg == $past(pend_reg))
        else $error("read word disturbed a pending argument");
endmodule
`default_nettype wire

/* hdl/tmt_back.sv */
// Back end: cursor state, text store, clear and scroll sweeps, result register.
`default_nettype none
module tmt_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_sel,
    input  wire logic [tmt_pkg::CFG_W-1:0] cfg_data,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire tmt_pkg::fe_word_t q_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [tmt_pkg::COL_W-1:0]  out_col,
    output logic [tmt_pkg::ROW_W-1:0]  out_row,
    output logic [tmt_pkg::IDX_W-1:0]  out_offset,
    output logic [tmt_pkg::CELL_W-1:0] out_cell
);
    import tmt_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              wr_en;

    logic              init_reg, init_next;   // clearing pass after reset
    bstate_t           st_reg, st_next;
    logic [COL_W-1:0]  scols_reg;
    logic [ROW_W-1:0]  srows_reg;
    logic [COL_W-1:0]  col_reg, col_next, scol_reg, scol_next;
    logic [ROW_W-1:0]  row_reg, row_next, srow_reg, srow_next;
    logic [7:0]        top_reg, top_next, bot_reg, bot_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next, end_reg, end_next;
    logic              dn_reg, dn_next;
    logic              ov_reg, ov_next;
    logic              rdz_reg, rdz_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [IDX_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  rowbase_reg, rowbase_next;

    logic [COL_W-1:0]  cols, cmax;
    logic [ROW_W-1:0]  rows, rmax;
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic              reg_ok;
    logic [IDX_W-1:0]  cells_all, top_base, bot_base, cur_addr;
    logic [7:0]        av, bv;

    always_comb begin
        cols = (scols_reg == '0) ? COL_W'(1)
             : (scols_reg > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : scols_reg;
        rows = (srows_reg == '0) ? ROW_W'(1)
             : (srows_reg > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : srows_reg;
        cmax = cols - COL_W'(1);
        rmax = rows - ROW_W'(1);
        ccol = (col_reg > cmax) ? cmax : col_reg;
        crow = (row_reg > rmax) ? rmax : row_reg;
        reg_ok    = top_reg < bot_reg && bot_reg < {2'b00, rows};
        cells_all = IDX_W'(rows) * IDX_W'(cols);
        top_base  = IDX_W'(top_reg) * IDX_W'(cols);
        bot_base  = IDX_W'(bot_reg) * IDX_W'(cols);
        cur_addr  = IDX_W'(crow) * IDX_W'(cols) + IDX_W'(ccol);
        av = q_word.arg_a - 8'd1;
        bv = q_word.arg_b - 8'd1;
    end

    assign q_ready    = !init_reg && st_reg == BS_IDLE && !ov_reg;
    assign out_valid  = ov_reg;
    assign out_col    = col_reg;
    assign out_row    = row_reg;
    assign out_offset = off_reg;
    assign out_cell   = rdz_reg ? '0 : cell_reg;

    always_comb begin
        st_next = st_reg; init_next = init_reg;
        col_next = col_reg; row_next = row_reg;
        scol_next = scol_reg; srow_next = srow_reg;
        top_next = top_reg; bot_next = bot_reg;
        ptr_next = ptr_reg; end_next = end_reg; dn_next = dn_reg;
        ov_next = ov_reg && !out_ready;
        rdz_next = rdz_reg; cell_next = cell_reg; off_next = off_reg;
        rowbase_next = rowbase_reg;
        rd_addr = ptr_reg; wr_addr = ptr_reg; wr_data = '0; wr_en = 1'b0;
        if (init_reg) begin
            wr_en = 1'b1;
            ptr_next = ptr_reg + IDX_W'(1);
            if (ptr_reg == IDX_W'(CELL_COUNT - 1)) begin
                init_next = 1'b0;
                ptr_next = '0;
            end
        end else begin
            case (st_reg)
                BS_IDLE: if (q_valid && q_ready) begin
                    col_next = ccol; row_next = crow;
                    rdz_next = 1'b1;
                    st_next  = BS_OUT;
                    case (q_word.op)
                        OP_READ: begin
                            rd_addr  = q_word.idx;
                            rdz_next = q_word.idx >= IDX_W'(CELL_COUNT);
                            st_next  = BS_READ;
                        end
                        OP_PUT: begin
                            wr_en = 1'b1; wr_addr = cur_addr;
                            wr_data = {ATTR_DEFAULT, q_word.arg_b};
                            if (ccol < cmax) col_next = ccol + COL_W'(1);
                        end
                        OP_CLEAR: begin
                            col_next = '0; row_next = '0;
                            ptr_next = '0; end_next = cells_all;
                            st_next = (cells_all == '0) ? BS_OUT : BS_CLEAR;
                        end
                        OP_SET_CUR: begin
                            col_next = (q_word.arg_a == 8'd0) ? '0
                                     : (av > {1'b0, cmax}) ? cmax : av[COL_W-1:0];
                            row_next = (q_word.arg_b == 8'd0) ? '0
                                     : (bv > {2'b00, rmax}) ? rmax : bv[ROW_W-1:0];
                        end
                        OP_SAVE_CUR: begin scol_next = ccol; srow_next = crow; end
                        OP_REST_CUR: begin
                            col_next = (scol_reg > cmax) ? cmax : scol_reg;
                            row_next = (srow_reg > rmax) ? rmax : srow_reg;
                        end
                        OP_SET_REG: begin top_next = av; bot_next = bv; end
                        OP_SCR_UP, OP_SCR_DN, OP_NEWLINE: begin
                            if (q_word.op == OP_NEWLINE) begin
                                col_next = '0;
                                if (bot_reg != {2'b00, crow} && crow < rmax)
                                    row_next = crow + ROW_W'(1);
                            end
                            if (reg_ok && (q_word.op != OP_NEWLINE
                                           || bot_reg == {2'b00, crow})) begin
                                dn_next = (q_word.op == OP_SCR_DN);
                                if (q_word.op == OP_SCR_DN) begin
                                    // walk downward from the last cell of the region
                                    ptr_next = bot_base + IDX_W'(cols) - IDX_W'(1);
                                    end_next = top_base + IDX_W'(cols);
                                    rowbase_next = top_base;
                                end else begin
                                    ptr_next = top_base;
                                    end_next = bot_base;
                                    rowbase_next = bot_base;
                                end
                                st_next = BS_MOVE_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                BS_READ: st_next = BS_OUT;
                BS_CLEAR: begin
                    wr_en = 1'b1;
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_next == end_reg) st_next = BS_OUT;
                end
                BS_MOVE_RD: begin
                    // source is one row below (up) or above (down)
                    if ((!dn_reg && ptr_reg == end_reg) ||
                        (dn_reg && ptr_reg < end_reg)) begin
                        ptr_next = rowbase_reg;
                        end_next = rowbase_reg + IDX_W'(cols);
                        st_next  = BS_FILL;
                    end else begin
                        rd_addr = dn_reg ? ptr_reg - IDX_W'(cols) : ptr_reg + IDX_W'(cols);
                        st_next = BS_MOVE_WR;
                    end
                end
                BS_MOVE_WR: begin
                    wr_en = 1'b1; wr_data = rd_data;
                    ptr_next = dn_reg ? ptr_reg - IDX_W'(1) : ptr_reg + IDX_W'(1);
                    st_next = BS_MOVE_RD;
                end
                BS_FILL: begin
                    wr_en = 1'b1;
                    ptr_next = ptr_reg + IDX_W'(1);
                    if (ptr_next == end_reg) st_next = BS_OUT;
                end
                BS_OUT: begin
                    cell_next = rd_data;
                    off_next  = IDX_W'(row_reg) * IDX_W'(cols) + IDX_W'(col_reg);
                    ov_next   = 1'b1;
                    st_next   = BS_IDLE;
                end
                default: st_next = BS_IDLE;
            endcase
        end
    end

    // BS_OUT always latches hold_reg, captured from rd_data in BS_READ; rdz zeroes other ops
    logic [CELL_W-1:0] hold_reg;
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
        if (st_reg == BS_READ) hold_reg <= rd_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= 1'b1; st_reg <= BS_IDLE;
            scols_reg <= COL_W'(80); srows_reg <= ROW_W'(25);
            col_reg <= '0; row_reg <= '0; scol_reg <= '0; srow_reg <= '0;
            top_reg <= '0; bot_reg <= '0; ptr_reg <= '0; end_reg <= '0;
            dn_reg <= 1'b0; ov_reg <= 1'b0; rdz_reg <= 1'b1;
        end else begin
            init_reg <= init_next; st_reg <= st_next;
            col_reg <= col_next; row_reg <= row_next;
            scol_reg <= scol_next; srow_reg <= srow_next;
            top_reg <= top_next; bot_reg <= bot_next;
            ptr_reg <= ptr_next; end_reg <= end_next;
            dn_reg <= dn_next; ov_reg <= ov_next; rdz_reg <= rdz_next;
            if (cfg_we && cfg_sel == CFG_COLS) scols_reg <= cfg_data;
            if (cfg_we && cfg_sel == CFG_ROWS) srows_reg <= cfg_data[ROW_W-1:0];
        end
        cell_reg <= (st_reg == BS_OUT) ? hold_reg : cell_next;
        off_reg <= off_next; rowbase_reg <= rowbase_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !out_ready |=> ov_reg && $stable(off_reg))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !q_ready)
        else $error("word taken during clearing pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != BS_IDLE |-> !ov_next || st_reg == BS_OUT || ov_reg)
        else $error("result raised outside output state");
endmodule
`default_nettype wire
